### rtl/core/kpc_pkg.sv
// Shared types and constants for the key press classifier.
package kpc_pkg;

    localparam int LONG_W   = 15;
    localparam int REPEAT_W = 16;
    localparam int COUNT_W  = 16;
    localparam int INDEX_W  = 2;
    localparam int WDATA_W  = 16;
    localparam int EVENT_W  = 2;

    localparam logic [INDEX_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_REPEAT_IVAL = 2'd1;
    localparam logic [INDEX_W-1:0] REG_AUTO_REPEAT = 2'd2;

    localparam logic [LONG_W-1:0]   LONG_PRESS_RESET  = 15'd100;
    localparam logic [REPEAT_W-1:0] REPEAT_IVAL_RESET = 16'd20;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } event_t;

    typedef struct packed {
        logic [LONG_W-1:0]   long_press_ticks;
        logic [REPEAT_W-1:0] repeat_interval_ticks;
        logic                auto_repeat_enable;
    } kpc_cfg_t;

endpackage

### rtl/core/kpc_core.sv
// Press phase machine, hold counter and event classification.
module kpc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              key_released,
    input  kpc_pkg::kpc_cfg_t cfg,
    output kpc_pkg::event_t   key_event
);
    import kpc_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   hold_reg, hold_next;
    logic                 armed_reg, armed_next;
    event_t               evt;
    logic [COUNT_W:0]     hold_plus2;
    logic [COUNT_W-1:0]   hold_inc;
    logic [COUNT_W:0]     inc_plus1;
    logic [LONG_W+1:0]    long_twice;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
            armed_reg <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            armed_reg <= armed_next;
        end
    end

    assign hold_plus2 = {1'b0, hold_reg} + (COUNT_W+1)'(2);
    assign hold_inc   = hold_reg + COUNT_W'(1);
    assign inc_plus1  = {1'b0, hold_inc} + (COUNT_W+1)'(1);
    assign long_twice = {1'b0, cfg.long_press_ticks, 1'b0};

    always_comb begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        armed_next = armed_reg;
        evt        = EVT_NONE;
        case (phase_reg)
            PH_IDLE: begin
                if (!key_released) begin
                    armed_next = 1'b0;
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                phase_next = key_released ? PH_IDLE : PH_HELD;
                hold_next  = '0;
            end
            PH_HELD: begin
                if (key_released) begin
                    phase_next = PH_IDLE;
                    evt        = EVT_SHORT;
                end else if (hold_plus2 > (COUNT_W+1)'(cfg.long_press_ticks)) begin
                    hold_next  = '0;
                    phase_next = PH_LONG;
                    evt        = EVT_LONG;
                end else begin
                    hold_next = hold_inc;
                end
            end
            PH_LONG: begin
                if (key_released) begin
                    phase_next = PH_IDLE;
                end else if (cfg.auto_repeat_enable) begin
                    hold_next = hold_inc;
                    if (armed_reg) begin
                        if (inc_plus1 > (COUNT_W+1)'(cfg.repeat_interval_ticks)) begin
                            hold_next = '0;
                            evt       = EVT_SHORT;
                        end
                    end else if (inc_plus1 > (COUNT_W+1)'(long_twice)) begin
                        hold_next  = '0;
                        armed_next = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign key_event = evt;

`ifndef SYNTH
    a_long_from_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && evt == EVT_LONG) |-> (phase_reg == PH_HELD))
        else $error("long event outside held phase");
    a_long_enters_long: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && evt == EVT_LONG) |=> (phase_reg == PH_LONG && hold_reg == '0))
        else $error("long event did not enter long-held phase");
    a_short_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && evt == EVT_SHORT) |-> (phase_reg == PH_HELD || phase_reg == PH_LONG))
        else $error("short event from idle or debounce");
    a_debounce_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_DEBOUNCE) |=> (hold_reg == '0))
        else $error("debounce did not clear counter");
`endif

endmodule

### rtl/core/key_press_classifier.sv
// Key press classifier: input word register, classification core, result register.
// A word is held in the input register; its event is held in the result register.
// One word per cycle unless stalled; the input register refills while a result waits.
// m_axis_tready low stalls the result register and, once the input register is full,
// s_axis_tready. Reset: registers return to 100, 20 and 0, the machine to idle with a
// cleared counter, and both stages empty.
module key_press_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [0] key_released
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [1:0] key_event
    input  logic                          cfg_we,
    input  logic [kpc_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [kpc_pkg::WDATA_W-1:0]   cfg_wdata
);
    import kpc_pkg::*;

    kpc_cfg_t cfg_reg;
    logic     in_valid_reg;
    logic     in_released_reg;
    logic     out_valid_reg;
    event_t   out_event_reg;
    event_t   core_event;
    logic     advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks      <= LONG_PRESS_RESET;
            cfg_reg.repeat_interval_ticks <= REPEAT_IVAL_RESET;
            cfg_reg.auto_repeat_enable    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LONG_PRESS:  cfg_reg.long_press_ticks      <= cfg_wdata[LONG_W-1:0];
                REG_REPEAT_IVAL: cfg_reg.repeat_interval_ticks <= cfg_wdata[REPEAT_W-1:0];
                REG_AUTO_REPEAT: cfg_reg.auto_repeat_enable    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_released_reg <= s_axis_tdata[0];
        end
    end

    kpc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .key_released (in_released_reg),
        .cfg          (cfg_reg),
        .key_event    (core_event)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= core_event;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_event_reg};

endmodule
